/* rtl/core/b64se_pkg.sv */
// Package for the base64 stream encoder: payload structs, queue entry type,
// phase codes, character constants and the alphabet lookup.
// No dependencies.
`timescale 1ns / 1ps

package b64se_pkg;

  localparam logic [7:0] CHAR_PAD = 8'h3d;
  localparam logic [7:0] CHAR_CR  = 8'h0d;
  localparam logic [7:0] CHAR_LF  = 8'h0a;
  localparam logic [4:0] DEFAULT_GROUPS = 5'd19;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       out_last;
  } out_item_t;

  // One classified byte: up to four characters, index of the final one,
  // and whether the byte ended the message.
  typedef struct packed {
    logic [3:0][7:0] chars;
    logic [1:0]      last_idx;
    logic            last;
  } cmd_t;

  typedef enum logic [1:0] {
    PH_0 = 2'd0,
    PH_1 = 2'd1,
    PH_2 = 2'd2
  } phase_t;

  function automatic logic [7:0] sym(input logic [5:0] idx);
    logic [7:0] wide;
    wide = {2'b00, idx};
    if (idx < 6'd26) begin
      sym = 8'(wide + 8'h41);
    end else if (idx < 6'd52) begin
      sym = 8'(wide + 8'h47);
    end else if (idx < 6'd62) begin
      sym = 8'(wide - 8'd4);
    end else if (idx == 6'd62) begin
      sym = 8'h2b;
    end else begin
      sym = 8'h2f;
    end
  endfunction

endpackage

/* rtl/core/b64se_front.sv */
// Front end: accepts raw bytes, tracks group phase, held bits and line
// group count, and turns each byte into one queue entry. Uses b64se_pkg.
`timescale 1ns / 1ps

module b64se_front import b64se_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  in_item_t in_item,
  input  logic     push_ready,
  output logic     push,
  output cmd_t     push_cmd,
  input  logic     cfg_we,
  input  logic [4:0] cfg_groups
);

  phase_t     phase_r, phase_nxt;
  logic [3:0] held_r, held_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic [4:0] gpl_r;
  logic [4:0] cnt_inc;
  logic [7:0] b;

  assign push = in_valid && push_ready;
  assign b = in_item.data_byte;
  assign cnt_inc = 5'(cnt_r + 5'd1);

  always_comb begin
    push_cmd  = '0;
    phase_nxt = phase_r;
    held_nxt  = held_r;
    cnt_nxt   = cnt_r;
    unique case (phase_r)
      PH_1: begin
        push_cmd.chars[0] = sym({held_r[1:0], b[7:4]});
        held_nxt  = b[3:0];
        phase_nxt = PH_2;
        if (in_item.last_byte) begin
          push_cmd.chars[1] = sym({b[3:0], 2'b00});
          push_cmd.chars[2] = CHAR_PAD;
          push_cmd.last_idx = 2'd2;
        end
      end
      PH_2: begin
        push_cmd.chars[0] = sym({held_r, b[7:6]});
        push_cmd.chars[1] = sym(b[5:0]);
        held_nxt  = 4'd0;
        phase_nxt = PH_0;
        if (cnt_inc == gpl_r) begin
          push_cmd.chars[2] = CHAR_CR;
          push_cmd.chars[3] = CHAR_LF;
          push_cmd.last_idx = 2'd3;
          cnt_nxt = 5'd0;
        end else begin
          push_cmd.last_idx = 2'd1;
          cnt_nxt = cnt_inc;
        end
      end
      default: begin
        // phase zero, and the unused code treated the same
        push_cmd.chars[0] = sym(b[7:2]);
        held_nxt  = {2'b00, b[1:0]};
        phase_nxt = PH_1;
        if (in_item.last_byte) begin
          push_cmd.chars[1] = sym({b[1:0], 4'd0});
          push_cmd.chars[2] = CHAR_PAD;
          push_cmd.chars[3] = CHAR_PAD;
          push_cmd.last_idx = 2'd3;
        end
      end
    endcase
    push_cmd.last = in_item.last_byte;
    if (in_item.last_byte) begin
      phase_nxt = PH_0;
      held_nxt  = 4'd0;
      cnt_nxt   = 5'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_0;
      held_r  <= 4'd0;
      cnt_r   <= 5'd0;
      gpl_r   <= DEFAULT_GROUPS;
    end else begin
      if (push) begin
        phase_r <= phase_nxt;
        held_r  <= held_nxt;
        cnt_r   <= cnt_nxt;
      end
      if (cfg_we) begin
        gpl_r <= cfg_groups;
      end
    end
  end

endmodule

/* rtl/core/b64se_queue.sv */
// Short FIFO of classified bytes between front and back ends.
// Uses b64se_pkg for the entry type.
`timescale 1ns / 1ps

module b64se_queue import b64se_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic push_ready,
  input  logic pop,
  output logic head_valid,
  output cmd_t head_cmd
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          entry_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  assign push_ready = (count_r != CW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = entry_r[rd_ptr_r];

  function automatic logic [PW-1:0] advance(input logic [PW-1:0] p);
    if (p == PW'(DEPTH - 1)) begin
      advance = '0;
    end else begin
      advance = PW'(p + 1'b1);
    end
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= advance(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= advance(rd_ptr_r);
      end
      if (push && !pop) begin
        count_r <= CW'(count_r + 1'b1);
      end else if (pop && !push) begin
        count_r <= CW'(count_r - 1'b1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count beyond depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("pop from empty queue");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> push_ready)
    else $error("push into full queue");

  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("pointers disagree on empty queue");

endmodule

/* rtl/core/b64se_back.sv */
// Back end: walks the characters of the head queue entry, one per cycle
// while the receiver accepts, into the output register. Uses b64se_pkg.
`timescale 1ns / 1ps

module b64se_back import b64se_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      head_valid,
  input  cmd_t      head_cmd,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic      out_valid_r;
  out_item_t out_data_r;
  logic [1:0] sel_r;
  logic      load, fire, at_end;

  assign load   = !out_valid_r || out_ready;
  assign fire   = load && head_valid;
  assign at_end = (sel_r == head_cmd.last_idx);
  assign pop    = fire && at_end;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r.out_char <= head_cmd.chars[sel_r];
      out_data_r.out_last <= head_cmd.last && at_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sel_r       <= 2'd0;
    end else begin
      if (load) begin
        out_valid_r <= head_valid;
      end
      if (fire) begin
        // advance through the entry, restart on its final character
        sel_r <= at_end ? 2'd0 : 2'(sel_r + 2'd1);
      end
    end
  end

  a_sel_in_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (sel_r != 2'd0) |-> (head_valid && sel_r <= head_cmd.last_idx))
    else $error("character index outside head entry");

  a_mid_entry_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && !at_end) |=> head_valid)
    else $error("entry lost mid way");

  a_last_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && head_cmd.last && !at_end) |=> !out_data_r.out_last)
    else $error("last flag before final character");

endmodule

/* rtl/core/base64_stream_encoder_unit.sv */
// Top level of the base64 stream encoder with MIME CR LF line breaks.
// Depends on b64se_pkg, b64se_front, b64se_queue and b64se_back.
//
// Input channel in_valid/in_ready/in_data carries one raw byte and its
// last-byte flag. Output channel out_valid/out_ready/out_data carries one
// character ('A'-'/', '=', CR or LF) with out_last set on the final
// character of a message. The cfg channel writes groups_per_line (5 bits,
// reset 19); cfg_ready is always high.
// Each byte yields one to four characters; the back end emits one
// character per cycle while out_ready allows it. The front end takes a
// new byte every cycle while the queue has room. The first character of a
// byte passes through the queue entry and then the output register before
// it is on out_valid.
// Reset clears the phase, held bits, line count, queue and output register
// and restores groups_per_line to 19. A stalled receiver holds the output
// register; the queue then fills and in_ready falls.
`timescale 1ns / 1ps

module base64_stream_encoder_unit import b64se_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [4:0] cfg_data
);

  logic push, push_ready, pop, head_valid;
  cmd_t push_cmd, head_cmd;

  assign cfg_ready = 1'b1;
  assign in_ready  = push_ready;

  b64se_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_item    (in_data),
    .push_ready (push_ready),
    .push       (push),
    .push_cmd   (push_cmd),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_groups (cfg_data)
  );

  b64se_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .push_ready (push_ready),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  b64se_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule
